@@ hw/rtl/stereo_state_variable_filter_defines.svh @@
// Assertion macros shared by the filter RTL.
// Each macro takes a label, the clock, the active-low reset and a property or condition.
`ifndef STEREO_STATE_VARIABLE_FILTER_DEFINES_SVH
`define STEREO_STATE_VARIABLE_FILTER_DEFINES_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define SSVF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property violated");

// Condition must never be true at a clock edge outside reset.
`define SSVF_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define SSVF_ASSERT(label, clk, rst_n, prop)
`define SSVF_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ hw/rtl/ssvf_pkg.sv @@
package ssvf_pkg;

  // Default sizes.
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // Stereo: left lane and right lane.
  localparam int CHANNELS   = 2;
  localparam int INTEG_BITS = 32;

  // Configuration register indexes.
  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_A1   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_A2   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_A3   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_AK   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_K    = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_MODE = 3'd5;

  // Output response select.
  localparam int MODE_BITS = 3;
  localparam logic [MODE_BITS-1:0] MODE_LOW     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_BAND    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_HIGH    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_NOTCH   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_PEAK    = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_ALLPASS = 3'd5;

  // Step strobes from the sequencer to every lane.
  typedef struct packed {
    logic load;
    logic mul0;
    logic mul1;
    logic mul2;
    logic mul3;
    logic kmul;
  } lane_ctrl_t;

endpackage

@@ hw/rtl/ssvf_lane.sv @@
module ssvf_lane #(
  parameter int SAMPLE_BITS    = ssvf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = ssvf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ssvf_pkg::lane_ctrl_t              ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  logic                              clear_i,
  input  logic [COEF_FRAC_BITS+1:0]         a1_i,
  input  logic [COEF_FRAC_BITS+1:0]         a2_i,
  input  logic [COEF_FRAC_BITS+1:0]         a3_i,
  input  logic [COEF_FRAC_BITS+1:0]         ak_i,
  input  logic [COEF_FRAC_BITS+1:0]         k_i,
  input  logic [ssvf_pkg::MODE_BITS-1:0]    mode_i,
  output logic signed [SAMPLE_BITS-1:0]     result_o
);
  import ssvf_pkg::*;

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int OP_BITS   = ((SAMPLE_BITS > INTEG_BITS) ? SAMPLE_BITS : INTEG_BITS) + 1;
  localparam int PROD_BITS = COEF_BITS + 1 + OP_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int R_BITS    = SUM_BITS - COEF_FRAC_BITS;
  localparam int V_BITS    = R_BITS + 1;
  localparam int LO_BITS   = V_BITS - OP_BITS;
  localparam int KSUM_BITS = PROD_BITS + LO_BITS + 2;
  localparam int KV_BITS   = KSUM_BITS - COEF_FRAC_BITS;
  localparam int Y_BITS    = KV_BITS + 2;
  localparam int T_BITS    = V_BITS + 2;

  localparam logic signed [SUM_BITS-1:0] HALF_S =
    {{(SUM_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [KSUM_BITS-1:0] HALF_K =
    {{(KSUM_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

  logic signed [INTEG_BITS-1:0] band_q, band_d, low_q, low_d;
  logic signed [OP_BITS-1:0]    v3_q;
  logic signed [PROD_BITS-1:0]  pa_q, pb_q, prod_a, prod_b;
  logic signed [V_BITS-1:0]     v0_q, v1_q, v2_q;

  logic [COEF_BITS-1:0]         coef_a, coef_b;
  logic signed [OP_BITS-1:0]    opnd_a, opnd_b;
  logic signed [SUM_BITS-1:0]   sum_sub, sum_add;
  logic signed [R_BITS-1:0]     rnd_sub, rnd_add;
  logic signed [KSUM_BITS-1:0]  ksum;
  logic signed [KV_BITS-1:0]    kv;
  logic signed [Y_BITS-1:0]     y;
  logic signed [T_BITS-1:0]     t_band, t_low;
  logic [Y_BITS-SAMPLE_BITS:0]  y_top;
  logic [T_BITS-INTEG_BITS:0]   band_top, low_top;
  logic signed [OP_BITS-1:0]    x_ext, ic2_ext;

  // Operand select: the two multipliers are reused over the steps.
  always_comb begin
    coef_a = a1_i;
    opnd_a = v3_q;
    coef_b = ak_i;
    opnd_b = OP_BITS'(band_q);
    if (ctrl_i.mul1) begin
      coef_a = a2_i;
      coef_b = a1_i;
    end else if (ctrl_i.mul2) begin
      coef_a = a3_i;
      coef_b = a2_i;
    end else if (ctrl_i.kmul) begin
      coef_a = k_i;
      opnd_a = v1_q[V_BITS-1:LO_BITS];
      coef_b = k_i;
      opnd_b = {{(OP_BITS-LO_BITS){1'b0}}, v1_q[LO_BITS-1:0]};
    end
  end

  assign prod_a = $signed({1'b0, coef_a}) * opnd_a;
  assign prod_b = $signed({1'b0, coef_b}) * opnd_b;

  // Round half up, then floor by the coefficient fraction.
  assign sum_sub = SUM_BITS'(pa_q) - SUM_BITS'(pb_q) + HALF_S;
  assign sum_add = SUM_BITS'(pa_q) + SUM_BITS'(pb_q) + HALF_S;
  assign rnd_sub = sum_sub[SUM_BITS-1:COEF_FRAC_BITS];
  assign rnd_add = sum_add[SUM_BITS-1:COEF_FRAC_BITS];

  // Damping product rebuilt from its high and low partial products.
  assign ksum = (KSUM_BITS'(pa_q) <<< LO_BITS) + KSUM_BITS'(pb_q) + HALF_K;
  assign kv   = ksum[KSUM_BITS-1:COEF_FRAC_BITS];

  assign x_ext   = OP_BITS'(sample_i);
  assign ic2_ext = clear_i ? '0 : OP_BITS'(low_q);

  // Integrator update, saturated to the state width.
  assign t_band   = (T_BITS'(v1_q) <<< 1) - T_BITS'(band_q);
  assign t_low    = (T_BITS'(v2_q) <<< 1) - T_BITS'(low_q);
  assign band_top = t_band[T_BITS-1:INTEG_BITS-1];
  assign low_top  = t_low[T_BITS-1:INTEG_BITS-1];

  always_comb begin
    band_d = band_q;
    low_d  = low_q;
    if (ctrl_i.load && clear_i) begin
      band_d = '0;
      low_d  = '0;
    end else if (ctrl_i.kmul) begin
      band_d = (&band_top || ~|band_top) ? t_band[INTEG_BITS-1:0]
             : {t_band[T_BITS-1], {(INTEG_BITS-1){~t_band[T_BITS-1]}}};
      low_d  = (&low_top || ~|low_top) ? t_low[INTEG_BITS-1:0]
             : {t_low[T_BITS-1], {(INTEG_BITS-1){~t_low[T_BITS-1]}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= '0;
      low_q  <= '0;
    end else begin
      band_q <= band_d;
      low_q  <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v3_q <= x_ext - ic2_ext;
    end
    if (ctrl_i.mul0 || ctrl_i.mul1 || ctrl_i.mul2 || ctrl_i.kmul) begin
      pa_q <= prod_a;
      pb_q <= prod_b;
    end
    if (ctrl_i.mul1) begin
      v0_q <= V_BITS'(rnd_sub);
    end
    if (ctrl_i.mul2) begin
      v1_q <= V_BITS'(rnd_add);
    end
    if (ctrl_i.mul3) begin
      v2_q <= V_BITS'(rnd_add) + V_BITS'(low_q);
    end
  end

  // Response select and output saturation.
  always_comb begin
    unique case (mode_i)
      MODE_LOW:     y = Y_BITS'(v2_q);
      MODE_BAND:    y = Y_BITS'(v1_q);
      MODE_HIGH:    y = Y_BITS'(v0_q);
      MODE_NOTCH:   y = Y_BITS'(v2_q) + Y_BITS'(v0_q);
      MODE_PEAK:    y = Y_BITS'(v2_q) - Y_BITS'(v0_q);
      MODE_ALLPASS: y = Y_BITS'(v2_q) + Y_BITS'(v0_q) - Y_BITS'(kv);
      default:      y = '0;
    endcase
  end

  assign y_top    = y[Y_BITS-1:SAMPLE_BITS-1];
  assign result_o = (&y_top || ~|y_top) ? y[SAMPLE_BITS-1:0]
                  : {y[Y_BITS-1], {(SAMPLE_BITS-1){~y[Y_BITS-1]}}};

endmodule

@@ hw/rtl/ssvf_merge.sv @@
module ssvf_merge #(
  parameter int SAMPLE_BITS = ssvf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          load_i,
  input  logic [ssvf_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] result_i,
  input  logic                                          out_ready_i,
  output logic                                          free_o,
  output logic                                          out_valid_o,
  output logic [ssvf_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] data_o
);
  import ssvf_pkg::*;

  logic                                 valid_q, valid_d;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] data_q;

  // Slot frees when empty or when the held result transfers this cycle.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

@@ hw/rtl/stereo_state_variable_filter.sv @@
// Stereo two-pole state-variable filter, one left/right sample pair per transfer.
// Each channel runs in its own lane: two integrator states, two coefficient
// multipliers reused over the steps of a sample, exact products, sums rounded
// half up to the coefficient fraction, integrators saturated to 32 bits and the
// selected response (low, band, high, notch, peak, all-pass; codes 6 and 7 give
// zero) saturated to the sample width. Coefficients a1, a2, a3, ak and the
// damping k are unsigned Q2.COEF_FRAC_BITS values written by software through
// the configuration port. Software must write them only while the filter is
// idle; the block itself does not enforce this. A set clear_state zeroes both
// integrators of every channel before the sample is filtered. Each sample's
// result is loaded into the output register after the sequencer steps MUL0,
// MUL1, MUL2, MUL3, KMUL and OUT; the OUT step waits until the output register
// has room. The lanes' pair of multipliers carries the six filter products and
// the two partial products of the all-pass damping term. A new input is taken
// once the previous result has moved into the output register, so a waiting
// result does not hold off the next sample's work.
`include "stereo_state_variable_filter_defines.svh"

module stereo_state_variable_filter #(
  parameter int SAMPLE_BITS    = ssvf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = ssvf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [ssvf_pkg::REG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [COEF_FRAC_BITS+1:0]            cfg_data_i,
  // Input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]        right_sample_i,
  input  logic                                 clear_state_i,
  // Output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        left_out_o,
  output logic signed [SAMPLE_BITS-1:0]        right_out_o
);
  import ssvf_pkg::*;

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;

  // Sequencer: accept, four coefficient steps, damping step, hand-off.
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL0 = 7'b0000010,
    ST_MUL1 = 7'b0000100,
    ST_MUL2 = 7'b0001000,
    ST_MUL3 = 7'b0010000,
    ST_KMUL = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [COEF_BITS-1:0] a1_q, a2_q, a3_q, ak_q, k_q;
  logic [MODE_BITS-1:0] mode_q;

  lane_ctrl_t                            lane_ctrl;
  logic                                  in_xfer;
  logic                                  res_load;
  logic                                  out_free;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  sample_vec;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  lane_result;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  out_data;

  // Register writes: indexes past the mode register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q   <= COEF_BITS'(1) << COEF_FRAC_BITS;
      a2_q   <= '0;
      a3_q   <= '0;
      ak_q   <= '0;
      k_q    <= COEF_BITS'(1) << COEF_FRAC_BITS;
      mode_q <= MODE_LOW;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_A1:   a1_q   <= cfg_data_i;
        REG_A2:   a2_q   <= cfg_data_i;
        REG_A3:   a3_q   <= cfg_data_i;
        REG_AK:   ak_q   <= cfg_data_i;
        REG_K:    k_q    <= cfg_data_i;
        REG_MODE: mode_q <= cfg_data_i[MODE_BITS-1:0];
        default:  ;
      endcase
    end
  end

  // Take a sample only while the lanes are free.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Hand the lane results over once the output register has room.
  assign res_load = (state_q == ST_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL0;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_KMUL;
      ST_KMUL: state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step strobes shared by all lanes.
  assign lane_ctrl.load = in_xfer;
  assign lane_ctrl.mul0 = (state_q == ST_MUL0);
  assign lane_ctrl.mul1 = (state_q == ST_MUL1);
  assign lane_ctrl.mul2 = (state_q == ST_MUL2);
  assign lane_ctrl.mul3 = (state_q == ST_MUL3);
  assign lane_ctrl.kmul = (state_q == ST_KMUL);

  assign sample_vec[0] = left_sample_i;
  assign sample_vec[1] = right_sample_i;

  // One filter lane per channel, all in lockstep.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    ssvf_lane #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (sample_vec[c]),
      .clear_i  (clear_state_i),
      .a1_i     (a1_q),
      .a2_i     (a2_q),
      .a3_i     (a3_q),
      .ak_i     (ak_q),
      .k_i      (k_q),
      .mode_i   (mode_q),
      .result_o (lane_result[c])
    );
  end

  // Gather the lane results into one output transfer.
  ssvf_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .result_i    (lane_result),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .data_o      (out_data)
  );

  assign left_out_o  = out_data[0];
  assign right_out_o = out_data[1];

  // An accepted sample starts the coefficient steps right away.
  `SSVF_ASSERT(a_accept_starts, clk_i, rst_ni, in_xfer |=> (state_q == ST_MUL0))
  // Never load a result over one that is still waiting.
  `SSVF_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, res_load && out_valid_o && !out_ready_i)
  // A blocked hand-off keeps the lanes parked.
  `SSVF_ASSERT(a_out_hold, clk_i, rst_ni, ((state_q == ST_OUT) && !out_free) |=> (state_q == ST_OUT))
  // A new result only appears after the hand-off step.
  `SSVF_ASSERT(a_valid_source, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == ST_OUT))

endmodule
